### hdl/mccf_pkg.sv
// Shared types and constants for the multi-channel color fader.
// Word formats, microcode opcodes and condition codes, sequencer status.
// No dependencies.
`timescale 1ns / 1ps

package mccf_pkg;

  localparam int unsigned NUM_CHANNELS_DEF  = 16;
  localparam int unsigned DURATION_BITS_DEF = 16;
  localparam int unsigned STEP_W            = 4;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  channel;
    logic [7:0]  target_red;
    logic [7:0]  target_green;
    logic [7:0]  target_blue;
    logic [15:0] duration;
    logic        blend_write;
    logic        blend_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       out_blending;
    logic       out_active;
  } out_word_t;

  // [0] red, [1] green, [2] blue
  typedef logic [2:0][7:0] rgb_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_FETCH,
    OP_RD_ITEM,
    OP_START_WR,
    OP_OUT,
    OP_CH_INIT,
    OP_RD_CH,
    OP_MUL,
    OP_DIV,
    OP_COMP,
    OP_TICK_WR,
    OP_CH_NEXT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_KIND_TICK,
    C_KIND_READ,
    C_SKIP_START,
    C_OUT_BUSY,
    C_INACTIVE,
    C_DIV_MORE,
    C_COMP_MORE,
    C_CH_MORE
  } cond_e;

  typedef struct packed {
    logic no_input;
    logic kind_tick;
    logic kind_read;
    logic skip_start;
    logic out_busy;
    logic inactive;
    logic div_more;
    logic comp_more;
    logic ch_more;
  } cond_t;

  typedef struct packed {
    logic load;
    logic step;
  } lerp_ctl_t;

endpackage

### hdl/multi_channel_color_fader.sv
// Multi-channel color fader top level: channel table memory, flags, I/O words.
// Depends on mccf_pkg, mccf_seq and mccf_lerp.
//
// A read word may wait for the output register to free up. A tick word
// walks the channel table and runs the interpolation only for fading
// channels. Tick cost is set by one shared interpolation unit that does a
// multiply and an 8-step restoring divide for each of the three
// components, and by the single-port channel table. A finished read word
// waits in the output register while the next word is taken in.
`timescale 1ns / 1ps

module multi_channel_color_fader import mccf_pkg::*; #(
  parameter int unsigned NUM_CHANNELS  = NUM_CHANNELS_DEF,
  parameter int unsigned DURATION_BITS = DURATION_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int unsigned CW = $clog2(NUM_CHANNELS);
  localparam int unsigned DW = DURATION_BITS;
  localparam logic [1:0]  LAST_COMP = 2'd2;

  typedef struct packed {
    rgb_t          cur;
    rgb_t          origin;
    rgb_t          target;
    logic [DW-1:0] len;
    logic [DW:0]   elapsed;
  } rec_t;

  op_e       op;
  cond_t     cond;
  lerp_ctl_t lctl;
  logic      div_more;
  logic [7:0] lerp_res;

  in_word_t  item_q;
  logic [3:0] ch_q;
  logic [CW-1:0] idx;
  logic      ch_bad;
  logic [DW-1:0] dur;
  logic      dur_zero;
  rgb_t      tgt;

  rec_t      mem_q [NUM_CHANNELS];
  rec_t      rd_q;
  rec_t      wdata;
  logic      we;
  logic      re;
  logic [CW-1:0] waddr;
  logic [CW-1:0] raddr;

  logic [NUM_CHANNELS-1:0] vld_q;
  logic [NUM_CHANNELS-1:0] act_q;
  logic [NUM_CHANNELS-1:0] blend_q;

  logic [CW-1:0] cnt_q;
  logic [1:0]    comp_q;
  rgb_t          newc_q;

  rgb_t          cur_eff;
  logic [DW:0]   el_inc;
  logic          fin;

  out_word_t out_q;
  logic      out_valid_q;
  logic      out_busy;
  logic      out_load;

  mccf_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .op_o   (op)
  );

  mccf_lerp #(
    .DW (DW)
  ) u_lerp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lctl),
    .a_i    (rd_q.origin[comp_q]),
    .b_i    (rd_q.target[comp_q]),
    .num_i  (DW'(rd_q.elapsed)),
    .den_i  (rd_q.len),
    .more_o (div_more),
    .res_o  (lerp_res)
  );

  assign in_ready_o = op == OP_FETCH;

  // item word
  always_ff @(posedge clk_i) begin
    if (op == OP_FETCH && in_valid_i) begin
      item_q <= in_word_i;
      ch_q   <= (in_word_i.kind == KIND_START && in_word_i.channel == 4'd0) ?
                4'd1 : in_word_i.channel;
    end
  end

  assign idx      = CW'(ch_q);
  assign ch_bad   = 32'(ch_q) >= NUM_CHANNELS;
  assign dur      = DW'(item_q.duration);
  assign dur_zero = dur == '0;
  assign tgt      = {item_q.target_blue, item_q.target_green, item_q.target_red};

  // unwritten entries read as their reset color
  assign cur_eff = vld_q[idx] ? rd_q.cur : ((idx == '0) ? rgb_t'('0) : rgb_t'('1));
  assign el_inc  = rd_q.elapsed + (DW+1)'(1);
  assign fin     = el_inc > (DW+1)'(rd_q.len);

  assign out_busy = out_valid_q && !out_ready_i;
  assign out_load = (op == OP_OUT) && !out_busy;

  assign lctl.load = op == OP_MUL;
  assign lctl.step = op == OP_DIV;

  always_comb begin
    cond.no_input   = !in_valid_i;
    cond.kind_tick  = item_q.kind == KIND_TICK;
    cond.kind_read  = item_q.kind == KIND_READ;
    cond.skip_start = (item_q.kind != KIND_START) || ch_bad;
    cond.out_busy   = out_busy;
    cond.inactive   = !act_q[cnt_q];
    cond.div_more   = div_more;
    cond.comp_more  = comp_q != LAST_COMP;
    cond.ch_more    = cnt_q != CW'(NUM_CHANNELS - 1);
  end

  // channel table port control
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rd_q;
    re    = (op == OP_RD_ITEM) || (op == OP_RD_CH);
    raddr = (op == OP_RD_CH) ? cnt_q : idx;
    case (op)
      OP_START_WR: begin
        we           = 1'b1;
        wdata.origin = cur_eff;
        wdata.target = tgt;
        if (dur_zero) begin
          wdata.cur = tgt;
        end else begin
          wdata.cur     = cur_eff;
          wdata.len     = dur;
          wdata.elapsed = '0;
        end
      end
      OP_TICK_WR: begin
        we            = 1'b1;
        waddr         = cnt_q;
        wdata.elapsed = el_inc;
        wdata.cur     = fin ? rd_q.target : newc_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  // per-channel flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      act_q   <= '0;
      blend_q <= '0;
    end else begin
      case (op)
        OP_START_WR: begin
          vld_q[idx] <= 1'b1;
          if (item_q.blend_write) begin
            blend_q[idx] <= item_q.blend_value;
          end
          if (!dur_zero) begin
            act_q[idx] <= 1'b1;
          end
        end
        OP_TICK_WR: begin
          vld_q[cnt_q] <= 1'b1;
          if (fin) begin
            act_q[cnt_q] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // tick walk counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      comp_q <= '0;
    end else begin
      case (op)
        OP_CH_INIT: cnt_q  <= CW'(1);
        OP_CH_NEXT: cnt_q  <= cnt_q + CW'(1);
        OP_RD_CH:   comp_q <= '0;
        OP_COMP:    comp_q <= comp_q + 2'd1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_COMP) begin
      newc_q[comp_q] <= lerp_res;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (ch_bad) begin
        out_q <= '0;
      end else begin
        out_q.out_red      <= cur_eff[0];
        out_q.out_green    <= cur_eff[1];
        out_q.out_blue     <= cur_eff[2];
        out_q.out_blending <= blend_q[idx];
        out_q.out_active   <= act_q[idx];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

### hdl/mccf_lerp.sv
// Interpolation unit: a + (b - a) * num / den for one 8-bit component.
// A multiply, then eight restoring divide steps. Uses mccf_pkg.
`timescale 1ns / 1ps

module mccf_lerp import mccf_pkg::*; #(
  parameter int unsigned DW = DURATION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lerp_ctl_t     ctl_i,
  input  logic [7:0]    a_i,
  input  logic [7:0]    b_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          more_o,
  output logic [7:0]    res_o
);

  localparam int unsigned PW = DW + 8;

  logic [PW-1:0] rem_q, rem_d;
  logic [PW-1:0] dsh_q, dsh_d;
  logic [7:0]    quo_q, quo_d;
  logic [7:0]    a_q;
  logic          neg_q;
  logic [2:0]    cnt_q, cnt_d;
  logic [7:0]    diff;
  logic          ge;

  assign diff = (b_i >= a_i) ? (b_i - a_i) : (a_i - b_i);
  assign ge   = rem_q >= dsh_q;

  always_comb begin
    rem_d = rem_q;
    dsh_d = dsh_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (ctl_i.load) begin
      rem_d = PW'(diff) * PW'(num_i);
      dsh_d = PW'(den_i) << 7;
      quo_d = '0;
      cnt_d = 3'd7;
    end else if (ctl_i.step) begin
      rem_d = ge ? (rem_q - dsh_q) : rem_q;
      dsh_d = dsh_q >> 1;
      quo_d = {quo_q[6:0], ge};
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    if (ctl_i.load) begin
      a_q   <= a_i;
      neg_q <= b_i < a_i;
    end
  end

  assign more_o = cnt_q != 3'd0;
  assign res_o  = neg_q ? (a_q - quo_q) : (a_q + quo_q);

endmodule

### hdl/mccf_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Issues one datapath opcode per cycle. Uses mccf_pkg.
`timescale 1ns / 1ps

module mccf_seq import mccf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cond_t cond_i,
  output op_e   op_o
);

  typedef struct packed {
    op_e                op;
    cond_e              cond;
    logic [STEP_W-1:0]  target;
  } ucode_t;

  localparam logic [STEP_W-1:0] S_FETCH    = 4'd0;
  localparam logic [STEP_W-1:0] S_DECODE   = 4'd1;
  localparam logic [STEP_W-1:0] S_RD_ITEM  = 4'd2;
  localparam logic [STEP_W-1:0] S_CHK      = 4'd3;
  localparam logic [STEP_W-1:0] S_START    = 4'd4;
  localparam logic [STEP_W-1:0] S_READ     = 4'd5;
  localparam logic [STEP_W-1:0] S_READ_END = 4'd6;
  localparam logic [STEP_W-1:0] S_TICK     = 4'd7;
  localparam logic [STEP_W-1:0] S_CH_LOOP  = 4'd8;
  localparam logic [STEP_W-1:0] S_MUL      = 4'd9;
  localparam logic [STEP_W-1:0] S_DIV      = 4'd10;
  localparam logic [STEP_W-1:0] S_COMP     = 4'd11;
  localparam logic [STEP_W-1:0] S_TICK_WR  = 4'd12;
  localparam logic [STEP_W-1:0] S_CH_NEXT  = 4'd13;
  localparam logic [STEP_W-1:0] S_TICK_END = 4'd14;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t uc;
    case (step)
      S_FETCH:    uc = '{OP_FETCH,    C_NO_INPUT,   S_FETCH};
      S_DECODE:   uc = '{OP_NONE,     C_KIND_TICK,  S_TICK};
      S_RD_ITEM:  uc = '{OP_RD_ITEM,  C_KIND_READ,  S_READ};
      S_CHK:      uc = '{OP_NONE,     C_SKIP_START, S_FETCH};
      S_START:    uc = '{OP_START_WR, C_ALWAYS,     S_FETCH};
      S_READ:     uc = '{OP_OUT,      C_OUT_BUSY,   S_READ};
      S_READ_END: uc = '{OP_NONE,     C_ALWAYS,     S_FETCH};
      S_TICK:     uc = '{OP_CH_INIT,  C_NEVER,      S_FETCH};
      S_CH_LOOP:  uc = '{OP_RD_CH,    C_INACTIVE,   S_CH_NEXT};
      S_MUL:      uc = '{OP_MUL,      C_NEVER,      S_FETCH};
      S_DIV:      uc = '{OP_DIV,      C_DIV_MORE,   S_DIV};
      S_COMP:     uc = '{OP_COMP,     C_COMP_MORE,  S_MUL};
      S_TICK_WR:  uc = '{OP_TICK_WR,  C_NEVER,      S_FETCH};
      S_CH_NEXT:  uc = '{OP_CH_NEXT,  C_CH_MORE,    S_CH_LOOP};
      S_TICK_END: uc = '{OP_NONE,     C_ALWAYS,     S_FETCH};
      default:    uc = '{OP_NONE,     C_ALWAYS,     S_FETCH};
    endcase
    return uc;
  endfunction

  logic [STEP_W-1:0] pc_q, pc_d;
  ucode_t            uc;
  logic              taken;

  assign uc = ucode_rom(pc_q);

  always_comb begin
    case (uc.cond)
      C_NEVER:      taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_NO_INPUT:   taken = cond_i.no_input;
      C_KIND_TICK:  taken = cond_i.kind_tick;
      C_KIND_READ:  taken = cond_i.kind_read;
      C_SKIP_START: taken = cond_i.skip_start;
      C_OUT_BUSY:   taken = cond_i.out_busy;
      C_INACTIVE:   taken = cond_i.inactive;
      C_DIV_MORE:   taken = cond_i.div_more;
      C_COMP_MORE:  taken = cond_i.comp_more;
      C_CH_MORE:    taken = cond_i.ch_more;
      default:      taken = 1'b0;
    endcase
  end

  assign pc_d = taken ? uc.target : (pc_q + STEP_W'(1));
  assign op_o = uc.op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
